// File: rtl/bba_pkg.sv
// shared types, codes and constants of the buddy block allocator
// no dependencies; used by bba_ctrl, bba_datapath and buddy_block_allocator
package bba_pkg;

  localparam int MAX_DEPTH_DEFAULT = 10;
  localparam int POOL_W = 23;
  localparam int ADDR_W = 32;

  localparam logic [POOL_W-1:0] SPLIT_MIN  = 23'h004002;
  localparam logic [POOL_W-1:0] POOL_RESET = 23'h002000;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic CFG_POOL_SIZE    = 1'b0;
  localparam logic CFG_BASE_ADDRESS = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ENTER,
    ST_CHK_A,
    ST_CHK_F,
    ST_SCAN,
    ST_SCAN_W,
    ST_RET,
    ST_PARENT,
    ST_PL,
    ST_PR,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_CUR,
    RD_LEFT,
    RD_RIGHT,
    RD_SCAN
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    logic    wr_val;
    logic    wr_clr;
    logic    clr_step;
    logic    go_left;
    logic    go_right;
    logic    go_up;
    logic    scan_start;
    logic    scan_step;
    logic    scan_next_lvl;
    logic    set_got;
    logic    latch_l;
    logic    out_load;
    logic    out_ok;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic size_lt_2req;
    logic size_ge_req;
    logic kids;
    logic at_root;
    logic phase;
    logic off_match;
    logic rdata;
    logic used_l;
    logic scan_last;
    logic scan_kids;
    logic clr_done;
  } sts_t;

endpackage

// File: rtl/buddy_block_allocator.sv
// Buddy block allocator over a tree of per-node used bits.
// Channels: cfg (cfg_valid/cfg_ready, cfg_index, cfg_data) writes pool_size
// (index 0) or base_address (index 1); always ready, write only while idle.
// in (in_valid/in_ready) takes operation, request_size, free_address.
// out (out_valid/out_ready) returns address and success, one per item.
// After reset a clearing pass writes all 2^(MAX_DEPTH+1)-1 used bits to zero,
// one per cycle; in_ready stays low until the pass is done.
// Each node entered on the walk is read, then checked; on the way back after a
// miss each node is passed through a return step, and after a hit both children
// are read again to update the parent. An allocate also reads the nodes covered
// by its free-subtree check. An item ends with the return at the root and the
// result load; the used-bit memory has a registered read. One item is
// worked on at a time; the next one is taken the cycle after the result load.
// The result sits in an output register; the next item is taken while it
// waits, and its walk runs to completion, then waits for out_ready.
// Depends on bba_pkg, bba_ctrl, bba_datapath.
module buddy_block_allocator #(
  parameter int MAX_DEPTH = bba_pkg::MAX_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [31:0]                cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       operation,
  input  logic [bba_pkg::POOL_W-1:0] request_size,
  input  logic [bba_pkg::ADDR_W-1:0] free_address,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bba_pkg::ADDR_W-1:0] address,
  output logic                       success
);
  import bba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bba_datapath #(.MAX_DEPTH(MAX_DEPTH)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .operation    (operation),
    .request_size (request_size),
    .free_address (free_address),
    .cmd          (cmd),
    .sts          (sts),
    .address      (address),
    .success      (success)
  );

endmodule

// File: rtl/bba_datapath.sv
// datapath: config registers, node used-bit memory, walk position and scan counters
// depends on bba_pkg; driven by bba_ctrl commands
module bba_datapath #(
  parameter int MAX_DEPTH = bba_pkg::MAX_DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [31:0]                 cfg_data,
  input  logic                        operation,
  input  logic [bba_pkg::POOL_W-1:0]  request_size,
  input  logic [bba_pkg::ADDR_W-1:0]  free_address,
  input  bba_pkg::cmd_t               cmd,
  output bba_pkg::sts_t               sts,
  output logic [bba_pkg::ADDR_W-1:0]  address,
  output logic                        success
);
  import bba_pkg::*;

  localparam int AW    = MAX_DEPTH + 1;
  localparam int NODES = (1 << AW) - 1;
  localparam int DW    = $clog2(MAX_DEPTH + 1);

  function automatic logic kids_at(input logic [DW-1:0] d, input logic [POOL_W-1:0] p);
    logic [POOL_W-1:0] s;
    s = p >> (d - 1'b1);
    if (32'(d) >= MAX_DEPTH) return 1'b0;
    else if (d == '0) return 1'b1;
    else return s >= SPLIT_MIN;
  endfunction

  logic [POOL_W-1:0] pool;
  logic [ADDR_W-1:0] base;
  logic              op;
  logic [POOL_W-1:0] req;
  logic [ADDR_W-1:0] target;
  logic [AW-1:0]     cur_idx;
  logic [DW-1:0]     cur_d;
  logic [POOL_W-1:0] cur_off;
  logic [MAX_DEPTH:0] phase;
  logic [POOL_W-1:0] got;
  logic [AW-1:0]     scan_base;
  logic [AW-1:0]     scan_j;
  logic [AW-1:0]     scan_width;
  logic [DW-1:0]     scan_d;
  logic [AW-1:0]     clr_ptr;
  logic              rdata;
  logic              used_l;
  logic              mem [NODES];

  logic [POOL_W-1:0] size;
  logic [POOL_W-1:0] half;
  logic [DW-1:0]     pd;
  logic [POOL_W-1:0] parent_half;
  logic [AW-1:0]     left_idx;
  logic [AW-1:0]     right_idx;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;

  assign size        = pool >> cur_d;
  assign half        = size >> 1;
  assign pd          = cur_d - 1'b1;
  assign parent_half = (pool >> pd) >> 1;
  assign left_idx    = {cur_idx[AW-2:0], 1'b1};
  assign right_idx   = {cur_idx[AW-2:0], 1'b0} + AW'(2);

  always_comb begin
    case (cmd.rd_sel)
      RD_CUR:   raddr = cur_idx;
      RD_LEFT:  raddr = left_idx;
      RD_RIGHT: raddr = right_idx;
      RD_SCAN:  raddr = scan_base + scan_j;
      default:  raddr = cur_idx;
    endcase
    waddr = cmd.wr_clr ? clr_ptr : cur_idx;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= cmd.wr_val;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool    <= POOL_RESET;
      base    <= '0;
      clr_ptr <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_POOL_SIZE) pool <= cfg_data[POOL_W-1:0];
        else base <= cfg_data;
      end
      if (cmd.clr_step) clr_ptr <= clr_ptr + 1'b1;
    end
  end

  // walk position, phase stack and subtree scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= operation;
      req     <= request_size;
      target  <= free_address - base;
      cur_idx <= '0;
      cur_d   <= '0;
      cur_off <= '0;
    end else if (cmd.go_left) begin
      phase[cur_d] <= 1'b0;
      cur_idx      <= left_idx;
      cur_d        <= cur_d + 1'b1;
    end else if (cmd.go_right) begin
      phase[cur_d] <= 1'b1;
      cur_idx      <= right_idx;
      cur_d        <= cur_d + 1'b1;
      cur_off      <= cur_off + half;
    end else if (cmd.go_up) begin
      cur_idx <= (cur_idx - 1'b1) >> 1;
      cur_d   <= pd;
      if (phase[pd]) cur_off <= cur_off - parent_half;
    end
    if (cmd.scan_start) begin
      scan_base  <= cur_idx;
      scan_j     <= '0;
      scan_width <= AW'(1);
      scan_d     <= cur_d;
    end else if (cmd.scan_next_lvl) begin
      scan_base  <= {scan_base[AW-2:0], 1'b1};
      scan_j     <= '0;
      scan_width <= scan_width << 1;
      scan_d     <= scan_d + 1'b1;
    end else if (cmd.scan_step) begin
      scan_j <= scan_j + 1'b1;
    end
    if (cmd.set_got) got <= cur_off;
    if (cmd.latch_l) used_l <= rdata;
    if (cmd.out_load) begin
      success <= cmd.out_ok;
      address <= (cmd.out_ok && op == OP_ALLOC) ? base + ADDR_W'(got) : '0;
    end
  end

  always_comb begin
    sts.op           = op;
    sts.size_lt_2req = {1'b0, size} < {req, 1'b0};
    sts.size_ge_req  = size >= req;
    sts.kids         = kids_at(cur_d, pool);
    sts.at_root      = cur_d == '0;
    sts.phase        = phase[cur_d];
    sts.off_match    = target == ADDR_W'(cur_off);
    sts.rdata        = rdata;
    sts.used_l       = used_l;
    sts.scan_last    = scan_j == scan_width - 1'b1;
    sts.scan_kids    = kids_at(scan_d, pool);
    sts.clr_done     = clr_ptr == AW'(NODES - 1);
  end

endmodule

// File: rtl/bba_ctrl.sv
// controller: sequences the depth-first walk, subtree scan and clearing pass
// depends on bba_pkg; commands bba_datapath
module bba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  bba_pkg::sts_t sts,
  output bba_pkg::cmd_t cmd
);
  import bba_pkg::*;

  state_t state, state_next;
  logic   ret_val, ret_val_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      ret_val   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ret_val   <= ret_val_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    ret_val_next = ret_val;
    cmd          = '0;
    cmd.rd_sel   = RD_CUR;
    in_ready     = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_clr   = 1'b1;
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_ENTER;
        end
      end
      ST_ENTER: begin
        if (sts.op == OP_ALLOC && sts.size_lt_2req) begin
          if (sts.size_ge_req) begin
            cmd.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end else begin
            ret_val_next = 1'b0;
            state_next   = ST_RET;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = (sts.op == OP_ALLOC) ? ST_CHK_A : ST_CHK_F;
        end
      end
      ST_CHK_A: begin
        if (sts.rdata) begin
          ret_val_next = 1'b0;
          state_next   = ST_RET;
        end else if (!sts.kids) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_val   = 1'b1;
          cmd.set_got  = 1'b1;
          ret_val_next = 1'b1;
          state_next   = ST_RET;
        end else begin
          cmd.go_left = 1'b1;
          state_next  = ST_ENTER;
        end
      end
      ST_CHK_F: begin
        if (sts.off_match && sts.rdata) begin
          cmd.wr_en    = 1'b1;
          ret_val_next = 1'b1;
          state_next   = ST_RET;
        end else if (!sts.kids) begin
          ret_val_next = 1'b0;
          state_next   = ST_RET;
        end else begin
          cmd.go_left = 1'b1;
          state_next  = ST_ENTER;
        end
      end
      ST_SCAN: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_SCAN;
        state_next = ST_SCAN_W;
      end
      ST_SCAN_W: begin
        if (sts.rdata) begin
          ret_val_next = 1'b0;
          state_next   = ST_RET;
        end else if (!sts.scan_last) begin
          cmd.scan_step = 1'b1;
          state_next    = ST_SCAN;
        end else if (sts.scan_kids) begin
          cmd.scan_next_lvl = 1'b1;
          state_next        = ST_SCAN;
        end else begin
          // whole subtree free: grant this node
          cmd.wr_en    = 1'b1;
          cmd.wr_val   = 1'b1;
          cmd.set_got  = 1'b1;
          ret_val_next = 1'b1;
          state_next   = ST_RET;
        end
      end
      ST_RET: begin
        if (sts.at_root) begin
          state_next = ST_DONE;
        end else begin
          cmd.go_up  = 1'b1;
          state_next = ST_PARENT;
        end
      end
      ST_PARENT: begin
        if (!ret_val) begin
          if (!sts.phase) begin
            cmd.go_right = 1'b1;
            state_next   = ST_ENTER;
          end else begin
            state_next = ST_RET;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LEFT;
          state_next = ST_PL;
        end
      end
      ST_PL: begin
        cmd.latch_l = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_RIGHT;
        state_next  = ST_PR;
      end
      ST_PR: begin
        // alloc marks parent full once both children are used, free clears it unless both children stay used
        if (sts.op == OP_ALLOC) begin
          cmd.wr_en  = sts.used_l && sts.rdata;
          cmd.wr_val = 1'b1;
        end else begin
          cmd.wr_en  = !(sts.used_l && sts.rdata);
          cmd.wr_val = 1'b0;
        end
        state_next = ST_RET;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          cmd.out_ok   = ret_val;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    if (cmd.out_load) out_valid_next = 1'b1;
  end

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == ST_ENTER)
    else $error("accepted transfer did not start a walk");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !in_ready)
    else $error("input ready during clearing pass");

  a_root_return_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RET && sts.at_root) |=> state == ST_DONE)
    else $error("return at root did not finish the item");

  a_load_only_done: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (state == ST_DONE && (!out_valid || out_ready)))
    else $error("result register overwritten while holding a result");

endmodule

// File: tb/tb.sv
// testbench for buddy_block_allocator: random and directed allocate/free traffic
// checked against a behavioral model of the buddy tree held in a scoreboard class
// depends on bba_pkg and the buddy_block_allocator rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int TREE_DEPTH = MAX_DEPTH_DEFAULT;
  localparam int NODES = (1 << (TREE_DEPTH + 1)) - 1;

  class alloc_board;
    bit          used[NODES];
    logic [31:0] pool;
    logic [31:0] base;
    logic [31:0] got_off;
    logic [31:0] want_addr[$];
    logic        want_ok[$];
    int          errors;

    function new();
      pool = POOL_RESET;
      base = '0;
      errors = 0;
      foreach (used[i]) used[i] = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
      if (idx == CFG_POOL_SIZE) pool = {9'd0, data[POOL_W-1:0]};
      else base = data;
    endfunction

    function bit splits(int depth);
      if (depth >= TREE_DEPTH) return 0;
      if (depth == 0) return 1;
      return (pool >> (depth - 1)) >= {9'd0, SPLIT_MIN};
    endfunction

    function bit busy_below(int idx, int depth);
      if (used[idx]) return 1;
      if (!splits(depth)) return 0;
      return busy_below(2*idx+1, depth+1) || busy_below(2*idx+2, depth+1);
    endfunction

    function bit grant(int idx, int depth, logic [31:0] off, logic [31:0] req);
      logic [31:0] size;
      size = pool >> depth;
      if ({32'd0, size} < 2 * {32'd0, req}) begin
        if (size >= req && !busy_below(idx, depth)) begin
          used[idx] = 1;
          got_off = off;
          return 1;
        end
        return 0;
      end
      if (used[idx]) return 0;
      if (!splits(depth)) begin
        used[idx] = 1;
        got_off = off;
        return 1;
      end
      if (!grant(2*idx+1, depth+1, off, req) &&
          !grant(2*idx+2, depth+1, off + (size >> 1), req))
        return 0;
      if (used[2*idx+1] && used[2*idx+2]) used[idx] = 1;
      return 1;
    endfunction

    function bit unmark(int idx, int depth, logic [31:0] off, logic [31:0] target);
      logic [31:0] size;
      size = pool >> depth;
      if (off == target && used[idx]) begin
        used[idx] = 0;
        return 1;
      end
      if (!splits(depth)) return 0;
      if (!unmark(2*idx+1, depth+1, off, target) &&
          !unmark(2*idx+2, depth+1, off + (size >> 1), target))
        return 0;
      if (!(used[2*idx+1] && used[2*idx+2])) used[idx] = 0;
      return 1;
    endfunction

    // predicts the result of an accepted item and queues it
    function void note(logic op, logic [22:0] req, logic [31:0] fa,
                       output logic [31:0] a, output logic ok);
      a = '0;
      ok = 0;
      if (op == OP_ALLOC) begin
        if (grant(0, 0, 32'd0, {9'd0, req})) begin
          a = base + got_off;
          ok = 1;
        end
      end else begin
        ok = unmark(0, 0, 32'd0, fa - base);
      end
      want_addr.push_back(a);
      want_ok.push_back(ok);
    endfunction

    function void check(logic [31:0] a, logic ok);
      logic [31:0] ea;
      logic        eo;
      if (want_ok.size() == 0) begin
        $error("unexpected result transfer: address %h success %b", a, ok);
        errors++;
        return;
      end
      ea = want_addr.pop_front();
      eo = want_ok.pop_front();
      if (a !== ea) begin
        $error("address mismatch: expected %h actual %h", ea, a);
        errors++;
      end
      if (ok !== eo) begin
        $error("success mismatch: expected %b actual %b", eo, ok);
        errors++;
      end
    endfunction

    function int pending();
      return want_ok.size();
    endfunction
  endclass

  logic                clk = 0;
  logic                rst;
  logic                cfg_valid, cfg_ready, cfg_index;
  logic [31:0]         cfg_data;
  logic                in_valid, in_ready, operation;
  logic [POOL_W-1:0]   request_size;
  logic [ADDR_W-1:0]   free_address;
  logic                out_valid, out_ready, success;
  logic [ADDR_W-1:0]   address;

  alloc_board  sb = new();
  logic [31:0] held[$];
  bit          no_idle;
  int          stall_left;

  buddy_block_allocator u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .request_size(request_size), .free_address(free_address),
    .out_valid(out_valid), .out_ready(out_ready), .address(address), .success(success)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // receiver side: random stalls, mostly short
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!no_idle) stall_left <= gap_len();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check(address, success);
  end

  task automatic send(input logic op, input logic [22:0] req, input logic [31:0] fa);
    logic [31:0] a;
    logic        ok;
    int          g;
    in_valid <= 1'b1;
    operation <= op;
    request_size <= req;
    free_address <= fa;
    do @(posedge clk); while (!in_ready);
    sb.note(op, req, fa, a, ok);
    if (op == OP_ALLOC && ok) held.push_back(a);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || !in_ready) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [31:0] data);
    drain();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_items(input int n, input bit hold_mid);
    int          r, k, j;
    logic [31:0] sz;
    for (int i = 0; i < n; i++) begin
      if (hold_mid && i == n / 2) drain();
      r = $urandom_range(0, 99);
      if (r < 50) begin
        // well-formed request near a node size of the current tree
        k = $urandom_range(0, 11);
        sz = sb.pool >> k;
        if ($urandom_range(0, 3) != 0 && sz > 1) sz = sz - $urandom_range(0, sz / 2);
        send(OP_ALLOC, sz[22:0], $urandom());
      end else if (r < 85 && held.size() > 0) begin
        j = $urandom_range(0, held.size() - 1);
        send(OP_FREE, 23'($urandom()), held[j]);
        held.delete(j);
      end else if (r < 92) begin
        send(OP_FREE, 23'($urandom()),
             sb.base + ($urandom_range(0, 64) << $urandom_range(8, 16)));
      end else begin
        send(1'($urandom_range(0, 1)), 23'($urandom()), $urandom());
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_POOL_SIZE;
    cfg_data <= '0;
    in_valid <= 1'b0;
    operation <= OP_ALLOC;
    request_size <= '0;
    free_address <= '0;
    no_idle = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    drain();

    // default tree: root of 8192 split into two 4096 leaves
    send(OP_ALLOC, 23'd0, 32'd0);
    send(OP_ALLOC, 23'd4096, 32'd0);
    send(OP_ALLOC, 23'd1, 32'd0);
    send(OP_FREE, 23'd0, 32'd0);
    send(OP_FREE, 23'd0, 32'd0);
    send(OP_FREE, 23'h7fffff, 32'd4096);
    send(OP_ALLOC, 23'd8192, 32'hffffffff);
    send(OP_ALLOC, 23'h7fffff, 32'd0);
    send(OP_FREE, 23'd0, 32'hffffffff);
    send(OP_FREE, 23'd0, 32'd0);
    send(OP_ALLOC, 23'd8193, 32'd0);
    send(OP_ALLOC, 23'd2049, 32'd0);
    random_items(200, 1);

    write_cfg(CFG_POOL_SIZE, 32'hff80_0000);
    write_cfg(CFG_BASE_ADDRESS, 32'hffffffff);
    send(OP_ALLOC, 23'd0, 32'd0);
    send(OP_ALLOC, 23'd0, 32'd0);
    random_items(60, 0);

    write_cfg(CFG_POOL_SIZE, 32'd100000);
    write_cfg(CFG_BASE_ADDRESS, $urandom());
    random_items(300, 1);

    // blocks kept across a resize
    write_cfg(CFG_POOL_SIZE, 32'd40000);
    write_cfg(CFG_BASE_ADDRESS, 32'd0);
    no_idle = 1;
    random_items(300, 0);
    no_idle = 0;

    write_cfg(CFG_POOL_SIZE, 32'h007fffff);
    write_cfg(CFG_BASE_ADDRESS, 32'hffffffff);
    send(OP_ALLOC, 23'h7fffff, 32'd0);
    send(OP_FREE, 23'd0, 32'hffffffff);
    random_items(80, 0);

    write_cfg(CFG_POOL_SIZE, 32'd20000);
    write_cfg(CFG_BASE_ADDRESS, 32'hfffff000);
    random_items(300, 0);

    write_cfg(CFG_POOL_SIZE, 32'd300000);
    write_cfg(CFG_BASE_ADDRESS, $urandom());
    random_items(250, 1);

    // free addresses below the base wrap around
    write_cfg(CFG_POOL_SIZE, 32'd8192);
    write_cfg(CFG_BASE_ADDRESS, 32'h1000);
    send(OP_FREE, 23'd0, 32'h0fff);
    send(OP_FREE, 23'd0, 32'h0000);
    send(OP_ALLOC, 23'd4096, 32'd0);
    send(OP_FREE, 23'd0, 32'h1000);
    random_items(250, 0);

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
